@@ hdl/fcpa_pkg.sv @@
// Package for the fixed cell pool allocator.
// Holds port field widths, request and status codes, controller states and the
// command and status structs passed between the controller and the datapath.
package fcpa_pkg;

   localparam int CELL_W    = 10;
   localparam int CFG_W     = 9;
   localparam int CFG_RESET = 16;

   localparam logic REQ_ALLOC  = 1'b0;
   localparam logic REQ_FREE   = 1'b1;
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_OOM = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CARVE,
      ST_READ,
      ST_POP
   } fcpa_state_type;

   typedef struct packed {
      logic push_free;
      logic carve_init;
      logic carve_step;
      logic rd_issue;
      logic pop;
      logic load_oom;
   } fcpa_cmd_type;

   typedef struct packed {
      logic head_empty;
      logic pool_done;
      logic carve_last;
   } fcpa_stat_type;

endpackage

@@ hdl/fcpa_datapath.sv @@
// Datapath of the fixed cell pool allocator: block size register, list head,
// carve pointer and counter, link store and the result payload registers.
// Depends on fcpa_pkg; driven by fcpa_ctrl through fcpa_cmd_type.
module fcpa_datapath
   import fcpa_pkg::*;
#(
   parameter int POOL_CELLS      = 1024,
   parameter int MAX_BLOCK_CELLS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_cells_per_block,
   input  logic [CELL_W-1:0] req_cell_index,
   input  fcpa_cmd_type      cmd,
   output fcpa_stat_type     stat,
   output logic              rsp_status,
   output logic [CELL_W-1:0] rsp_granted_cell
);

   localparam int AW = (POOL_CELLS > 1) ? $clog2(POOL_CELLS) : 1;
   localparam int LW = $clog2(POOL_CELLS + 1);
   localparam int BW = $clog2(MAX_BLOCK_CELLS + 1);
   localparam int SW = (BW > CFG_W) ? BW : CFG_W;
   localparam int KW = (LW > SW) ? LW : SW;
   localparam int IW = (LW > CELL_W) ? LW : CELL_W;
   localparam logic [LW-1:0] EMPTY = LW'(POOL_CELLS);

   logic [CFG_W-1:0]  cfg_ff;
   logic [LW-1:0]     head_ff, head_in;
   logic [LW-1:0]     carve_ff, carve_in;
   logic [BW-1:0]     cnt_ff, cnt_in;
   logic [LW-1:0]     rd_ff;
   logic              status_ff, status_in;
   logic [CELL_W-1:0] grant_ff, grant_in;

   logic [LW-1:0]     link_mem [POOL_CELLS];
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [LW-1:0]     mem_wd;

   logic [SW-1:0]     blk_size;
   logic [LW-1:0]     left;
   logic [KW-1:0]     carve_n;
   logic [IW-1:0]     free_cell;
   logic              free_ok;
   logic [LW-1:0]     nxt;

   always_comb begin
      if (cfg_ff == '0) begin
         blk_size = SW'(1);
      end else if (SW'(cfg_ff) > SW'(MAX_BLOCK_CELLS)) begin
         blk_size = SW'(MAX_BLOCK_CELLS);
      end else begin
         blk_size = SW'(cfg_ff);
      end
      left      = EMPTY - carve_ff;
      carve_n   = (KW'(blk_size) > KW'(left)) ? KW'(left) : KW'(blk_size);
      free_cell = IW'(req_cell_index);
      free_ok   = free_cell < IW'(POOL_CELLS);
      nxt       = (rd_ff > EMPTY) ? EMPTY : rd_ff;
   end

   assign stat.head_empty = (head_ff == EMPTY);
   assign stat.pool_done  = (carve_ff == EMPTY);
   assign stat.carve_last = (cnt_ff == BW'(1));

   always_comb begin
      head_in   = head_ff;
      carve_in  = carve_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      grant_in  = grant_ff;
      mem_we    = 1'b0;
      mem_wa    = head_ff[AW-1:0];
      mem_wd    = EMPTY;
      if (cmd.push_free) begin
         status_in = STATUS_OK;
         grant_in  = '0;
         if (free_ok) begin
            mem_we  = 1'b1;
            mem_wa  = free_cell[AW-1:0];
            mem_wd  = head_ff;
            head_in = free_cell[LW-1:0];
         end
      end
      if (cmd.load_oom) begin
         status_in = STATUS_OOM;
         grant_in  = '0;
      end
      if (cmd.carve_init) begin
         cnt_in = BW'(carve_n);
      end
      if (cmd.carve_step) begin
         mem_we   = 1'b1;
         mem_wa   = carve_ff[AW-1:0];
         mem_wd   = head_ff;
         head_in  = carve_ff;
         carve_in = carve_ff + LW'(1);
         cnt_in   = cnt_ff - BW'(1);
      end
      if (cmd.pop) begin
         mem_we    = 1'b1;
         mem_wa    = head_ff[AW-1:0];
         mem_wd    = EMPTY;
         head_in   = nxt;
         status_in = STATUS_OK;
         grant_in  = CELL_W'(IW'(head_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_W'(CFG_RESET);
         head_ff  <= EMPTY;
         carve_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            cfg_ff <= csr_cells_per_block;
         end
         head_ff  <= head_in;
         carve_ff <= carve_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      grant_ff  <= grant_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_wa] <= mem_wd;
      end
      if (cmd.rd_issue) begin
         rd_ff <= link_mem[head_ff[AW-1:0]];
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_granted_cell = grant_ff;

endmodule

@@ hdl/fcpa_ctrl.sv @@
// Controller of the fixed cell pool allocator: request and result handshakes
// and the state machine that sequences carve, link read and pop.
// Depends on fcpa_pkg; commands fcpa_datapath.
module fcpa_ctrl
   import fcpa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_type,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  fcpa_stat_type stat,
   output fcpa_cmd_type  cmd
);

   fcpa_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;
   logic           accept;
   logic           load;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !slot_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_FREE) begin
                  cmd.push_free = 1'b1;
                  load          = 1'b1;
               end else if (!stat.head_empty) begin
                  cmd.rd_issue = 1'b1;
                  state_in     = ST_POP;
               end else if (stat.pool_done) begin
                  cmd.load_oom = 1'b1;
                  load         = 1'b1;
               end else begin
                  cmd.carve_init = 1'b1;
                  state_in       = ST_CARVE;
               end
            end
         end
         ST_CARVE: begin
            cmd.carve_step = 1'b1;
            if (stat.carve_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_POP;
         end
         ST_POP: begin
            if (slot_free) begin
               cmd.pop  = 1'b1;
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/fixed_cell_pool_allocator.sv @@
// Fixed cell pool allocator: LIFO free list over a link store, block carving.
// Free: answered in the cycle after acceptance. Allocate from the list: link read,
// then pop in ST_POP when the result slot is free. Allocate that carves n cells:
// ST_CARVE (one link store write per cycle), ST_READ, ST_POP. One item in flight.
// Synchronous reset: list empty, nothing carved, block size 16; links not cleared.
module fixed_cell_pool_allocator
   import fcpa_pkg::*;
#(
   parameter int POOL_CELLS      = 1024,
   parameter int MAX_BLOCK_CELLS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_cells_per_block,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [CELL_W-1:0] req_cell_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_status,
   output logic [CELL_W-1:0] rsp_granted_cell
);

   fcpa_cmd_type  cmd;
   fcpa_stat_type stat;

   fcpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fcpa_datapath #(
      .POOL_CELLS      (POOL_CELLS),
      .MAX_BLOCK_CELLS (MAX_BLOCK_CELLS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_cells_per_block (csr_cells_per_block),
      .req_cell_index      (req_cell_index),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_status          (rsp_status),
      .rsp_granted_cell    (rsp_granted_cell)
   );

endmodule

@@ hdl/fcpa_checker.sv @@
// Port-level checker for the fixed cell pool allocator, bound to the top level.
// Depends on fcpa_pkg for codes and widths.
module fcpa_checker
   import fcpa_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_type,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_status,
   input logic [CELL_W-1:0] rsp_granted_cell
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_granted_cell))
      else $error("stalled result changed");

   a_oom_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OOM) |-> rsp_granted_cell == '0)
      else $error("exhausted result carries a cell");

   a_free_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == REQ_FREE) |=>
         rsp_valid && (rsp_status == STATUS_OK) && (rsp_granted_cell == '0))
      else $error("free item did not answer next cycle");

   a_alloc_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == REQ_ALLOC) |=> rsp_valid || req_stall)
      else $error("allocate accepted without result or busy");

endmodule

bind fixed_cell_pool_allocator fcpa_checker u_fcpa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_type         (req_type),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_granted_cell (rsp_granted_cell)
);
